/* hw/rtl/shfd_pkg.sv */
package shfd_pkg;

    localparam int HEADER_BYTES = 27;
    localparam int COUNT_W      = $clog2(HEADER_BYTES + 1);

    // Index of the checksum byte, and bytes left after dropping the sync pair
    localparam logic [COUNT_W-1:0] HDR_LAST_IDX = COUNT_W'(HEADER_BYTES - 1);
    localparam logic [COUNT_W-1:0] RESCAN_START = COUNT_W'(HEADER_BYTES - 2);

    localparam logic [7:0] SYNC_FIRST  = 8'h7E;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    localparam logic       KIND_HEADER  = 1'b0;
    localparam logic       KIND_PAYLOAD = 1'b1;

    localparam logic [1:0] END_NONE = 2'd0;
    localparam logic [1:0] END_GOOD = 2'd1;
    localparam logic [1:0] END_BAD  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic sync_load;     // start a header with the sync pair
        logic hdr_write;     // store the word at the fill position
        logic hdr_mismatch;  // last header word, tag wrong: drop the sync pair
        logic hdr_match;     // last header word, tag right: emit header
        logic pay_step;      // emit one payload word
        logic rescan_shift;  // drop one held byte during rescan
        logic count_clear;   // rescan ended without a pair
    } shfd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic byte_first;
        logic byte_second;
        logic hdr_last;
        logic tag_match;
        logic len_zero;
        logic pay_last;
        logic pair_at_head;
        logic head_first;
        logic count_ge2;
        logic count_one;
    } shfd_status_t;

endpackage

/* hw/rtl/shfd_ctrl.sv */
module shfd_ctrl
    import shfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  shfd_status_t status,
    output shfd_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_SAW_FIRST,
        ST_HEADER,
        ST_PAYLOAD,
        ST_RESCAN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_stall  = (state_reg == ST_RESCAN) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_HUNT:
            begin
                if (accept && status.byte_first)
                begin
                    state_next = ST_SAW_FIRST;
                end
            end
            ST_SAW_FIRST:
            begin
                if (accept)
                begin
                    if (status.byte_second)
                    begin
                        cmd.sync_load = 1'b1;
                        state_next    = ST_HEADER;
                    end
                    else if (!status.byte_first)
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_HEADER:
            begin
                if (accept)
                begin
                    if (!status.hdr_last)
                    begin
                        cmd.hdr_write = 1'b1;
                    end
                    else if (status.tag_match)
                    begin
                        cmd.hdr_match = 1'b1;
                        state_next    = status.len_zero ? ST_HUNT : ST_PAYLOAD;
                    end
                    else
                    begin
                        cmd.hdr_mismatch = 1'b1;
                        state_next       = ST_RESCAN;
                    end
                end
            end
            ST_PAYLOAD:
            begin
                if (accept)
                begin
                    cmd.pay_step = 1'b1;
                    if (status.pay_last)
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_RESCAN:
            begin
                if (status.count_ge2)
                begin
                    if (status.pair_at_head)
                    begin
                        state_next = ST_HEADER;
                    end
                    else
                    begin
                        cmd.rescan_shift = 1'b1;
                    end
                end
                else
                begin
                    // Keep a trailing first sync byte pending
                    cmd.count_clear = 1'b1;
                    state_next = (status.count_one && status.head_first) ?
                                 ST_SAW_FIRST : ST_HUNT;
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.hdr_match || cmd.pay_step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HUNT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hw/rtl/shfd_datapath.sv */
module shfd_datapath
    import shfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [7:0]   rx_byte,
    input  logic         cfg_write,
    input  logic [15:0]  cfg_data,
    input  shfd_cmd_t    cmd,
    output shfd_status_t status,
    output logic         item_kind,
    output logic [1:0]   frame_end,
    output logic [31:0]  source_node,
    output logic [31:0]  source_socket,
    output logic [7:0]   source_router,
    output logic [7:0]   proto_version,
    output logic [15:0]  sequence_number,
    output logic [15:0]  service_ident,
    output logic [15:0]  command_ident,
    output logic [31:0]  company_ident,
    output logic [15:0]  payload_length,
    output logic [7:0]   payload_byte
);

    logic [7:0]         hdr_reg  [HEADER_BYTES];
    logic [7:0]         hdr_next [HEADER_BYTES];
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [15:0]        remaining_reg, remaining_next;
    logic [7:0]         xor_reg, xor_next;
    logic [15:0]        tag_reg;
    logic [7:0]         hdr_xor;
    logic [7:0]         pay_xor;

    assign hdr_xor = hdr_reg[24] ^ hdr_reg[25];
    assign pay_xor = xor_reg ^ rx_byte;

    assign status.byte_first   = (rx_byte == SYNC_FIRST);
    assign status.byte_second  = (rx_byte == SYNC_SECOND);
    assign status.hdr_last     = (count_reg == HDR_LAST_IDX);
    assign status.tag_match    = ({hdr_reg[11], hdr_reg[12]} == tag_reg);
    assign status.len_zero     = ({hdr_reg[24], hdr_reg[25]} == 16'd0);
    assign status.pay_last     = (remaining_reg == 16'd1);
    assign status.pair_at_head = (hdr_reg[0] == SYNC_FIRST) && (hdr_reg[1] == SYNC_SECOND);
    assign status.head_first   = (hdr_reg[0] == SYNC_FIRST);
    assign status.count_ge2    = (count_reg >= COUNT_W'(2));
    assign status.count_one    = (count_reg == COUNT_W'(1));

    // Header byte store
    always_comb
    begin
        hdr_next = hdr_reg;
        if (cmd.sync_load)
        begin
            hdr_next[0] = SYNC_FIRST;
            hdr_next[1] = SYNC_SECOND;
        end
        if (cmd.hdr_write)
        begin
            for (int k = 0; k < HEADER_BYTES; k++)
            begin
                if (count_reg == COUNT_W'(k))
                begin
                    hdr_next[k] = rx_byte;
                end
            end
        end
        if (cmd.hdr_mismatch)
        begin
            // Drop the sync pair; the incoming word lands behind the rest
            for (int k = 0; k < HEADER_BYTES - 3; k++)
            begin
                hdr_next[k] = hdr_reg[k + 2];
            end
            hdr_next[HEADER_BYTES - 3] = rx_byte;
        end
        if (cmd.hdr_match)
        begin
            hdr_next[HEADER_BYTES - 1] = rx_byte;
        end
        if (cmd.rescan_shift)
        begin
            for (int k = 0; k < HEADER_BYTES - 1; k++)
            begin
                hdr_next[k] = hdr_reg[k + 1];
            end
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        remaining_next = remaining_reg;
        xor_next       = xor_reg;
        if (cmd.sync_load)
        begin
            count_next = COUNT_W'(2);
        end
        if (cmd.hdr_write)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        if (cmd.hdr_mismatch)
        begin
            count_next = RESCAN_START;
        end
        if (cmd.hdr_match || cmd.count_clear)
        begin
            count_next = '0;
        end
        if (cmd.rescan_shift)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
        if (cmd.hdr_match)
        begin
            remaining_next = {hdr_reg[24], hdr_reg[25]};
            xor_next       = hdr_xor;
        end
        if (cmd.pay_step)
        begin
            remaining_next = remaining_reg - 16'd1;
            xor_next       = pay_xor;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            remaining_reg <= '0;
            xor_reg       <= '0;
            tag_reg       <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            remaining_reg <= remaining_next;
            xor_reg       <= xor_next;
            if (cfg_write)
            begin
                tag_reg <= cfg_data;
            end
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (cmd.hdr_match)
        begin
            item_kind       <= KIND_HEADER;
            if (status.len_zero)
            begin
                frame_end <= (hdr_xor == rx_byte) ? END_GOOD : END_BAD;
            end
            else
            begin
                frame_end <= END_NONE;
            end
            source_node     <= {hdr_reg[2], hdr_reg[3], hdr_reg[4], hdr_reg[5]};
            source_socket   <= {hdr_reg[6], hdr_reg[7], hdr_reg[8], hdr_reg[9]};
            source_router   <= hdr_reg[10];
            proto_version   <= hdr_reg[13];
            sequence_number <= {hdr_reg[14], hdr_reg[15]};
            service_ident   <= {hdr_reg[16], hdr_reg[17]};
            command_ident   <= {hdr_reg[18], hdr_reg[19]};
            company_ident   <= {hdr_reg[20], hdr_reg[21], hdr_reg[22], hdr_reg[23]};
            payload_length  <= {hdr_reg[24], hdr_reg[25]};
            payload_byte    <= '0;
        end
        else if (cmd.pay_step)
        begin
            item_kind       <= KIND_PAYLOAD;
            if (status.pay_last)
            begin
                frame_end <= (pay_xor == hdr_reg[HEADER_BYTES - 1]) ? END_GOOD : END_BAD;
            end
            else
            begin
                frame_end <= END_NONE;
            end
            source_node     <= '0;
            source_socket   <= '0;
            source_router   <= '0;
            proto_version   <= '0;
            sequence_number <= '0;
            service_ident   <= '0;
            command_ident   <= '0;
            company_ident   <= '0;
            payload_length  <= '0;
            payload_byte    <= rx_byte;
        end
    end

endmodule

/* hw/rtl/sync_header_frame_deframer_top.sv */
// Channel   Direction  Handshake            Word
// input     in         in_valid / in_stall  rx_byte
// output    out        out_valid/out_stall  item_kind, frame_end, header fields, payload_byte
// config    in         cfg_valid/cfg_ready  cfg_data (expected second tag)
//
// One stream byte per cycle is taken while hunting, filling the header and
// passing payload; each header or payload word is registered and shows in the
// cycle after its input byte. A second-tag mismatch starts a rescan of the
// held header bytes, one byte per cycle, with input stalled.
// Input stalls while a finished word waits under out_stall. Reset clears the
// parser state and sets the expected tag to zero; cfg_ready is always high.
module sync_header_frame_deframer_top
    import shfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        item_kind,
    output logic [1:0]  frame_end,
    output logic [31:0] source_node,
    output logic [31:0] source_socket,
    output logic [7:0]  source_router,
    output logic [7:0]  proto_version,
    output logic [15:0] sequence_number,
    output logic [15:0] service_ident,
    output logic [15:0] command_ident,
    output logic [31:0] company_ident,
    output logic [15:0] payload_length,
    output logic [7:0]  payload_byte,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    shfd_cmd_t    cmd;
    shfd_status_t status;
    logic         cfg_write;

    // Take a tag write on any cycle
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Sequence sync hunt, header fill, rescan and payload
    shfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold header bytes, counters, checksum and the output word
    shfd_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_byte         (rx_byte),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .status          (status),
        .item_kind       (item_kind),
        .frame_end       (frame_end),
        .source_node     (source_node),
        .source_socket   (source_socket),
        .source_router   (source_router),
        .proto_version   (proto_version),
        .sequence_number (sequence_number),
        .service_ident   (service_ident),
        .command_ident   (command_ident),
        .company_ident   (company_ident),
        .payload_length  (payload_length),
        .payload_byte    (payload_byte)
    );

endmodule

/* bench/tb_sync_header_frame_deframer_top.sv */
module tb_sync_header_frame_deframer_top;
    import shfd_pkg::*;

    // Give up on the run well past the slowest legal schedule: every byte
    // waiting its longest gap, every result its longest stall and every tag
    // mismatch its longest rescan.
    localparam int CYCLE_LIMIT  = 400_000;
    // Quiet cycles after the last result: covers a rescan still running
    // after a header that produced no word.
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_BYTES  = 220;

    typedef enum logic [1:0] {P_HUNT, P_SAW_FIRST, P_HEADER, P_PAYLOAD} parse_phase_t;
    typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} header_fill_t;

    // One output word as the deframer should emit it
    typedef struct packed {
        logic        kind;
        logic [1:0]  fend;
        logic [31:0] node;
        logic [31:0] socket;
        logic [7:0]  router;
        logic [7:0]  version;
        logic [15:0] seq;
        logic [15:0] service;
        logic [15:0] command;
        logic [31:0] company;
        logic [15:0] length;
        logic [7:0]  pbyte;
    } deframed_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        item_kind;
    logic [1:0]  frame_end;
    logic [31:0] source_node;
    logic [31:0] source_socket;
    logic [7:0]  source_router;
    logic [7:0]  proto_version;
    logic [15:0] sequence_number;
    logic [15:0] service_ident;
    logic [15:0] command_ident;
    logic [31:0] company_ident;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'h0000;

    sync_header_frame_deframer_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .item_kind       (item_kind),
        .frame_end       (frame_end),
        .source_node     (source_node),
        .source_socket   (source_socket),
        .source_router   (source_router),
        .proto_version   (proto_version),
        .sequence_number (sequence_number),
        .service_ident   (service_ident),
        .command_ident   (command_ident),
        .company_ident   (company_ident),
        .payload_length  (payload_length),
        .payload_byte    (payload_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Deframer prediction: parser state mirrored at the block's widths
    // ------------------------------------------------------------------
    parse_phase_t   phase = P_HUNT;
    logic [7:0]     hold [HEADER_BYTES];
    int             fill = 0;
    logic [15:0]    remaining = 16'h0000;
    logic [7:0]     xor_acc = 8'h00;
    logic [15:0]    expected_tag = 16'h0000;
    deframed_word_t deframed_words [$];

    function automatic logic [15:0] be16(input int pos);
        return {hold[pos], hold[pos + 1]};
    endfunction

    function automatic logic [31:0] be32(input int pos);
        return {be16(pos), be16(pos + 2)};
    endfunction

    function automatic logic [1:0] checksum_verdict();
        return (xor_acc == hold[HEADER_BYTES - 1]) ? END_GOOD : END_BAD;
    endfunction

    // Drop the sync pair and look for the next pair among the held bytes;
    // bytes from that pair on become the start of a new header.
    task automatic rescan_held();
        int found;
        found = -1;
        for (int i = 2; i + 1 < HEADER_BYTES; i++)
        begin
            if (found < 0 && hold[i] == SYNC_FIRST && hold[i + 1] == SYNC_SECOND)
                found = i;
        end
        if (found >= 0)
        begin
            for (int j = 0; j + found < HEADER_BYTES; j++)
                hold[j] = hold[j + found];
            fill  = HEADER_BYTES - found;
            phase = P_HEADER;
        end
        else
        begin
            // a trailing first sync byte still counts as a pending sync
            fill  = 0;
            phase = (hold[HEADER_BYTES - 1] == SYNC_FIRST) ? P_SAW_FIRST : P_HUNT;
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        deframed_word_t w;
        w = '0;
        case (phase)
            P_HUNT:
            begin
                if (b == SYNC_FIRST)
                    phase = P_SAW_FIRST;
            end
            P_SAW_FIRST:
            begin
                if (b == SYNC_SECOND)
                begin
                    hold[0] = SYNC_FIRST;
                    hold[1] = SYNC_SECOND;
                    fill    = 2;
                    phase   = P_HEADER;
                end
                else if (b != SYNC_FIRST)
                begin
                    phase = P_HUNT;
                end
            end
            P_HEADER:
            begin
                if (fill >= HEADER_BYTES)
                begin
                    fill  = 0;
                    phase = P_HUNT;
                end
                else
                begin
                    hold[fill] = b;
                    fill++;
                    if (fill == HEADER_BYTES)
                    begin
                        if (be16(11) != expected_tag)
                        begin
                            rescan_held();
                        end
                        else
                        begin
                            fill      = 0;
                            remaining = be16(24);
                            xor_acc   = hold[24] ^ hold[25];
                            w.kind    = KIND_HEADER;
                            w.node    = be32(2);
                            w.socket  = be32(6);
                            w.router  = hold[10];
                            w.version = hold[13];
                            w.seq     = be16(14);
                            w.service = be16(16);
                            w.command = be16(18);
                            w.company = be32(20);
                            w.length  = remaining;
                            if (remaining == 16'h0000)
                            begin
                                w.fend = checksum_verdict();
                                phase  = P_HUNT;
                            end
                            else
                            begin
                                w.fend = END_NONE;
                                phase  = P_PAYLOAD;
                            end
                            deframed_words.push_back(w);
                        end
                    end
                end
            end
            P_PAYLOAD:
            begin
                xor_acc = xor_acc ^ b;
                if (remaining != 16'h0000)
                    remaining--;
                w.kind  = KIND_PAYLOAD;
                w.pbyte = b;
                if (remaining == 16'h0000)
                begin
                    w.fend = checksum_verdict();
                    phase  = P_HUNT;
                end
                else
                begin
                    w.fend = END_NONE;
                end
                deframed_words.push_back(w);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    int mismatches = 0;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, seen);
            mismatches++;
        end
    endtask

    // Compare the word on the output ports with the oldest prediction
    task automatic check_word();
        deframed_word_t want;
        if (deframed_words.size() == 0)
        begin
            $error("item_kind: expected no word, actual %0h", item_kind);
            mismatches++;
        end
        else
        begin
            want = deframed_words.pop_front();
            check_field("item_kind", want.kind, item_kind);
            check_field("frame_end", want.fend, frame_end);
            check_field("source_node", want.node, source_node);
            check_field("source_socket", want.socket, source_socket);
            check_field("source_router", want.router, source_router);
            check_field("proto_version", want.version, proto_version);
            check_field("sequence_number", want.seq, sequence_number);
            check_field("service_ident", want.service, service_ident);
            check_field("command_ident", want.command, command_ident);
            check_field("company_ident", want.company, company_ident);
            check_field("payload_length", want.length, payload_length);
            check_field("payload_byte", want.pbyte, payload_byte);
        end
    endtask

    // ------------------------------------------------------------------
    // Sampling at the rising edge: check the output word first, then
    // predict from the input word, so a word that leaves at this edge is
    // never matched against a prediction made at the same edge.
    // ------------------------------------------------------------------
    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_word();
        if (rst_n && in_valid && !in_stall)
            deframe_byte(rx_byte);
        in_fire  <= rst_n && in_valid && !in_stall;
        out_fire <= rst_n && out_valid && !out_stall;
    end

    // ------------------------------------------------------------------
    // Driver: pop stream bytes at the falling edge, hold each one until
    // it is taken, then wait a drawn gap before offering the next.
    // ------------------------------------------------------------------
    logic [7:0] stream_bytes [$];
    int         send_gap_max = 15;
    int         send_gap = 0;
    logic       sending = 1'b0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
                sending = 1'b0;
            if (!sending && stream_bytes.size() > 0)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else
                begin
                    rx_byte  <= stream_bytes.pop_front();
                    sending  = 1'b1;
                    send_gap = $urandom_range(send_gap_max, 0);
                end
            end
            // one assignment per edge: valid stays high across back-to-back words
            in_valid <= sending;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall each output word for a drawn number of cycles
    // ------------------------------------------------------------------
    int   recv_stall_max = 15;
    int   stall_left = 0;
    logic stall_now;

    always @(negedge clk)
    begin
        if (out_fire)
            stall_left = $urandom_range(recv_stall_max, 0);
        stall_now = rst_n && out_valid && stall_left > 0;
        if (stall_now)
            stall_left--;
        out_stall <= stall_now;
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stream building
    // ------------------------------------------------------------------
    int frame_bytes_queued = 0;

    // Lean toward the sync values so stray pairs show up inside headers
    function automatic logic [7:0] stream_random_byte();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 10)
            return SYNC_FIRST;
        if (pick < 15)
            return SYNC_SECOND;
        return 8'($urandom_range(255, 0));
    endfunction

    // Build one frame: sync, header, checksum, payload. A pair position of
    // 2..25 plants a sync pair there, 26 plants a lone first sync byte at
    // the checksum position; both are applied after the checksum is set.
    function automatic void build_frame(ref logic [7:0] q [$], input logic [15:0] tag,
                                        input int len, input header_fill_t hfill,
                                        input bit corrupt, input int pair_at);
        logic [7:0] hdr [HEADER_BYTES];
        logic [7:0] pay [$];
        logic [7:0] sum;
        for (int i = 0; i < HEADER_BYTES; i++)
        begin
            case (hfill)
                FILL_ZERO: hdr[i] = 8'h00;
                FILL_ONES: hdr[i] = 8'hFF;
                default:   hdr[i] = stream_random_byte();
            endcase
        end
        hdr[0]  = SYNC_FIRST;
        hdr[1]  = SYNC_SECOND;
        hdr[11] = tag[15:8];
        hdr[12] = tag[7:0];
        hdr[24] = 8'(len >> 8);
        hdr[25] = 8'(len);
        sum     = hdr[24] ^ hdr[25];
        for (int i = 0; i < len; i++)
        begin
            pay.push_back(8'($urandom_range(255, 0)));
            sum = sum ^ pay[i];
        end
        hdr[26] = corrupt ? (sum ^ (8'h01 << $urandom_range(7, 0))) : sum;
        if (pair_at >= 2 && pair_at <= 25)
        begin
            hdr[pair_at]     = SYNC_FIRST;
            hdr[pair_at + 1] = SYNC_SECOND;
        end
        else if (pair_at == 26)
        begin
            hdr[26] = SYNC_FIRST;
        end
        for (int i = 0; i < HEADER_BYTES; i++)
            q.push_back(hdr[i]);
        for (int i = 0; i < len; i++)
            q.push_back(pay[i]);
    endfunction

    task automatic queue_frame(input logic [15:0] tag, input int len,
                               input header_fill_t hfill, input bit corrupt,
                               input int pair_at, input int keep_bytes);
        logic [7:0] q [$];
        build_frame(q, tag, len, hfill, corrupt, pair_at);
        // keep_bytes < 0: whole frame; otherwise cut the frame short
        if (keep_bytes >= 0)
        begin
            while (q.size() > keep_bytes)
                void'(q.pop_back());
        end
        frame_bytes_queued += q.size();
        stream_bytes = {stream_bytes, q};
    endtask

    // Queue a frame that misses its tag but carries a good frame inside its
    // header starting at byte k (13..25); the rescan has to find it and the
    // rest of the inner frame follows on the stream.
    task automatic queue_nested_frame(input int k, input int len);
        logic [7:0] inner [$];
        logic [7:0] outer [$];
        build_frame(inner, expected_tag, len, FILL_RANDOM, 1'b0, -1);
        build_frame(outer, ~expected_tag, 0, FILL_RANDOM, 1'b0, -1);
        for (int i = 2; i < k; i++)
        begin
            if (outer[i] == SYNC_FIRST)
                outer[i] = 8'h00;
        end
        for (int i = k; i < HEADER_BYTES; i++)
            outer[i] = inner[i - k];
        for (int i = 0; i < HEADER_BYTES; i++)
            stream_bytes.push_back(outer[i]);
        for (int i = HEADER_BYTES - k; i < inner.size(); i++)
            stream_bytes.push_back(inner[i]);
        frame_bytes_queued += HEADER_BYTES + inner.size() - (HEADER_BYTES - k);
    endtask

    // Noise between frames; it leans toward the sync values and can hold stray pairs
    task automatic queue_noise(input int n);
        for (int i = 0; i < n; i++)
            stream_bytes.push_back(stream_random_byte());
    endtask

    function automatic int draw_payload_len();
        return ($urandom_range(99, 0) < 80) ? $urandom_range(8, 0) : $urandom_range(40, 9);
    endfunction

    function automatic logic [15:0] draw_wrong_tag();
        return expected_tag ^ 16'($urandom_range(16'hFFFF, 1));
    endfunction

    // Pick how hard both sides throttle for the next stretch of traffic
    task automatic pick_idle_mode();
        int pick;
        pick = $urandom_range(99, 0);
        send_gap_max   = (pick < 60 || (pick >= 75 && pick < 90)) ? 15 : 0;
        recv_stall_max = (pick < 75) ? 15 : 0;
    endtask

    task automatic wait_sent();
        while (stream_bytes.size() > 0)
            @(posedge clk);
    endtask

    // Wait until every byte is taken and every predicted word has come out
    task automatic wait_drained();
        while (stream_bytes.size() > 0 || in_valid || deframed_words.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_second_tag(input logic [15:0] tag);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= tag;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        expected_tag = tag;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed frames with random content, the rest broken
    // frames, tag misses, truncations and noise; throttling changes
    // every few frames.
    task automatic queue_random_traffic(input int byte_goal);
        int start;
        int frames;
        int pick;
        start  = frame_bytes_queued;
        frames = 0;
        while (frame_bytes_queued - start < byte_goal)
        begin
            if (frames % 6 == 0)
            begin
                wait_sent();
                pick_idle_mode();
            end
            frames++;
            pick = $urandom_range(99, 0);
            if (pick < 55)
                queue_frame(expected_tag, draw_payload_len(), FILL_RANDOM, 1'b0, -1, -1);
            else if (pick < 65)
                queue_frame(expected_tag, draw_payload_len(), FILL_RANDOM, 1'b1, -1, -1);
            else if (pick < 75)
                queue_frame(draw_wrong_tag(), draw_payload_len(), FILL_RANDOM, 1'b0,
                            ($urandom_range(3, 0) == 0) ? -1 : $urandom_range(26, 2), -1);
            else if (pick < 83)
                queue_nested_frame($urandom_range(25, 13), draw_payload_len());
            else if (pick < 90)
                queue_frame(expected_tag, draw_payload_len(), FILL_RANDOM, 1'b0, -1,
                            $urandom_range(HEADER_BYTES + 2, 1));
            else
                queue_noise($urandom_range(6, 1));
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed part, under the tag value left by reset
        send_gap_max   = 15;
        recv_stall_max = 15;
        // lone first sync byte, then one followed by a real sync pair
        stream_bytes.push_back(SYNC_FIRST);
        stream_bytes.push_back(8'h55);
        stream_bytes.push_back(SYNC_FIRST);
        queue_frame(expected_tag, 0, FILL_ZERO, 1'b0, -1, -1);
        // empty payload with a bad checksum, all-ones header fields
        queue_frame(expected_tag, 0, FILL_ONES, 1'b1, -1, -1);
        queue_frame(expected_tag, 1, FILL_RANDOM, 1'b0, -1, -1);
        queue_frame(expected_tag, 3, FILL_ONES, 1'b1, -1, -1);
        // tag miss with no pair to rescan onto
        queue_frame(16'h1234, 0, FILL_ZERO, 1'b0, -1, -1);
        // tag miss ending in a first sync byte; the next frame is cut after its header
        queue_frame(16'h4321, 0, FILL_ZERO, 1'b0, 26, -1);
        queue_frame(expected_tag, 2, FILL_RANDOM, 1'b0, -1, 27);
        queue_noise(0);
        stream_bytes.push_back(8'hAA);
        queue_frame(expected_tag, 2, FILL_RANDOM, 1'b0, -1, -1);
        // tag miss with good frames inside the held header
        queue_nested_frame(13, 2);
        queue_nested_frame(25, 0);
        queue_frame(16'hBEEF, 0, FILL_RANDOM, 1'b0, 2, -1);
        queue_frame(expected_tag, 4, FILL_RANDOM, 1'b0, -1, -1);
        wait_drained();

        // Random part over several tag settings, extremes among them
        write_second_tag(16'hFFFF);
        queue_random_traffic(PHASE_BYTES);
        write_second_tag({SYNC_FIRST, SYNC_SECOND});
        queue_random_traffic(PHASE_BYTES);
        write_second_tag(16'($urandom_range(16'hFFFF, 0)));
        queue_random_traffic(PHASE_BYTES);
        write_second_tag(16'h0000);
        queue_random_traffic(PHASE_BYTES);
        write_second_tag(16'($urandom_range(16'hFFFF, 0)));
        queue_random_traffic(PHASE_BYTES);

        // One long payload, at full rate to keep the run short
        write_second_tag(16'($urandom_range(16'hFFFF, 0)));
        send_gap_max   = 0;
        recv_stall_max = 0;
        queue_frame(expected_tag, 300, FILL_RANDOM, 1'b1, -1, -1);
        wait_drained();

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
